### rtl/bldg_pkg.sv
package bldg_pkg;

    // sample width default
    localparam int SAMPLE_BITS_DEFAULT = 8;

    // configuration port geometry
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 8;

    // register indexes on the configuration port
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GOOD_LEVEL       = 4'd0,
        REG_WARN_LEVEL       = 4'd1,
        REG_CRITICAL_LEVEL   = 4'd2,
        REG_DUTY_LIMIT       = 4'd3,
        REG_BEAT_TICKS       = 4'd4,
        REG_BLINK_TICKS_GOOD = 4'd5,
        REG_BLINK_TICKS_WARN = 4'd6,
        REG_BLINK_TICKS_LOW  = 4'd7
    } reg_index_t;

    // register reset values
    localparam logic [7:0] GOOD_LEVEL_RST       = 8'd133;
    localparam logic [7:0] WARN_LEVEL_RST       = 8'd128;
    localparam logic [7:0] CRITICAL_LEVEL_RST   = 8'd123;
    localparam logic [7:0] DUTY_LIMIT_RST       = 8'd250;
    localparam logic [7:0] BEAT_TICKS_RST       = 8'd10;
    localparam logic [7:0] BLINK_TICKS_GOOD_RST = 8'd100;
    localparam logic [7:0] BLINK_TICKS_WARN_RST = 8'd30;
    localparam logic [7:0] BLINK_TICKS_LOW_RST  = 8'd10;

    // configuration register set
    typedef struct packed {
        logic [7:0] good_level;
        logic [7:0] warn_level;
        logic [7:0] critical_level;
        logic [7:0] duty_limit;
        logic [7:0] beat_ticks;
        logic [7:0] blink_ticks_good;
        logic [7:0] blink_ticks_warn;
        logic [7:0] blink_ticks_low;
    } cfg_t;

    // governor state carried from tick to tick
    typedef struct packed {
        logic [7:0] duty;
        logic [7:0] beat_count;
        logic       beat;
        logic [7:0] blink_count;
        logic       led;
    } gov_state_t;

    // one result item
    typedef struct packed {
        logic [7:0] duty;
        logic       led_level;
        logic       beat_level;
        logic       shutdown;
    } result_t;

endpackage

### rtl/bldg_in_if.sv
interface bldg_in_if #(
    parameter int SAMPLE_BITS = bldg_pkg::SAMPLE_BITS_DEFAULT
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

### rtl/bldg_out_if.sv
interface bldg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty;
    logic       led_level;
    logic       beat_level;
    logic       shutdown;

    modport source (output valid, output duty, output led_level, output beat_level,
                    output shutdown, input ready);
    modport sink   (input valid, input duty, input led_level, input beat_level,
                    input shutdown, output ready);
endinterface

### rtl/bldg_step.sv
module bldg_step #(
    parameter int SAMPLE_BITS = bldg_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic [SAMPLE_BITS-1:0] sample,
    input  bldg_pkg::cfg_t         cfg,
    input  bldg_pkg::gov_state_t   state,
    output bldg_pkg::gov_state_t   state_next,
    output bldg_pkg::result_t      result
);
    import bldg_pkg::*;

    logic       good;
    logic       warn;
    logic       critical;
    logic [7:0] beat_inc;
    logic [7:0] blink_inc;
    logic [7:0] period;
    logic [7:0] duty_ramp;

    // voltage bands
    assign good     = sample > SAMPLE_BITS'(cfg.good_level);
    assign warn     = sample > SAMPLE_BITS'(cfg.warn_level);
    assign critical = sample < SAMPLE_BITS'(cfg.critical_level);

    // blink period follows the band
    assign period = good ? cfg.blink_ticks_good
                  : (warn ? cfg.blink_ticks_warn : cfg.blink_ticks_low);

    assign beat_inc  = state.beat_count + 8'd1;
    assign blink_inc = state.blink_count + 8'd1;

    // duty ramp by band
    always_comb
    begin
        if (good)
        begin
            duty_ramp = (state.duty < cfg.duty_limit) ? state.duty + 8'd1 : state.duty;
        end
        else if (warn)
        begin
            duty_ramp = (state.duty != 8'd0) ? state.duty - 8'd1 : 8'd0;
        end
        else
        begin
            duty_ramp = (state.duty < 8'd2) ? 8'd0 : state.duty - 8'd2;
        end
    end

    // next state and result
    always_comb
    begin
        state_next = state;
        result     = '0;
        if (critical)
        begin
            state_next.duty = 8'd0;
            state_next.led  = 1'b0;
            state_next.beat = 1'b1;
            result.shutdown = 1'b1;
        end
        else
        begin
            // heartbeat counter
            if (beat_inc >= cfg.beat_ticks)
            begin
                state_next.beat_count = 8'd0;
                state_next.beat       = ~state.beat;
            end
            else
            begin
                state_next.beat_count = beat_inc;
            end
            // status blink counter
            if (blink_inc >= period)
            begin
                state_next.blink_count = 8'd0;
                state_next.led         = ~state.led;
            end
            else
            begin
                state_next.blink_count = blink_inc;
            end
            // duty over the limit drops to zero
            state_next.duty   = (duty_ramp > cfg.duty_limit) ? 8'd0 : duty_ramp;
            result.duty       = state_next.duty;
            result.led_level  = state_next.led;
            result.beat_level = state_next.beat;
        end
    end

endmodule

### rtl/battery_load_duty_governor_core.sv
// Battery load duty governor. Takes one battery voltage sample per transfer on
// samples and returns one result per sample on results: the load duty, the
// status LED level, the heartbeat level and a shutdown flag for samples below
// the critical level. A sample is registered, worked through one short layer
// of compares and counter updates, and lands in the result register, so a
// sample can be accepted every clock cycle while results is not stalled. Its
// result is offered on results from the result register until it is taken.
// While a finished result waits, the sample register can still take one
// sample. Registers must be written by the user through cfg_we / cfg_index /
// cfg_data only while no sample is in flight; the block does not enforce this.
// An index beyond the register list is ignored.
module battery_load_duty_governor_core #(
    parameter int SAMPLE_BITS = bldg_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bldg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bldg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    bldg_in_if.sink                             samples,
    bldg_out_if.source                          results
);
    import bldg_pkg::*;

    cfg_t                   cfg_reg;
    cfg_t                   cfg_next;
    gov_state_t             state_reg;
    gov_state_t             state_next;
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   out_valid_reg;
    result_t                result_reg;
    result_t                result_next;
    logic                   advance;

    // register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GOOD_LEVEL:       cfg_next.good_level       = cfg_data;
                REG_WARN_LEVEL:       cfg_next.warn_level       = cfg_data;
                REG_CRITICAL_LEVEL:   cfg_next.critical_level   = cfg_data;
                REG_DUTY_LIMIT:       cfg_next.duty_limit       = cfg_data;
                REG_BEAT_TICKS:       cfg_next.beat_ticks       = cfg_data;
                REG_BLINK_TICKS_GOOD: cfg_next.blink_ticks_good = cfg_data;
                REG_BLINK_TICKS_WARN: cfg_next.blink_ticks_warn = cfg_data;
                REG_BLINK_TICKS_LOW:  cfg_next.blink_ticks_low  = cfg_data;
                default:              cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.good_level       <= GOOD_LEVEL_RST;
            cfg_reg.warn_level       <= WARN_LEVEL_RST;
            cfg_reg.critical_level   <= CRITICAL_LEVEL_RST;
            cfg_reg.duty_limit       <= DUTY_LIMIT_RST;
            cfg_reg.beat_ticks       <= BEAT_TICKS_RST;
            cfg_reg.blink_ticks_good <= BLINK_TICKS_GOOD_RST;
            cfg_reg.blink_ticks_warn <= BLINK_TICKS_WARN_RST;
            cfg_reg.blink_ticks_low  <= BLINK_TICKS_LOW_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // pipeline handshake
    assign advance       = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !in_valid_reg || advance;

    // governor step
    bldg_step #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_step (
        .sample     (sample_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.duty        <= 8'd0;
            state_reg.beat_count  <= 8'd0;
            state_reg.beat        <= 1'b1;
            state_reg.blink_count <= 8'd0;
            state_reg.led         <= 1'b0;
        end
        else
        begin
            if (samples.ready)
            begin
                in_valid_reg <= samples.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            sample_reg <= samples.sample;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.duty       = result_reg.duty;
    assign results.led_level  = result_reg.led_level;
    assign results.beat_level = result_reg.beat_level;
    assign results.shutdown   = result_reg.shutdown;

endmodule

### rtl/bldg_checker.sv
module bldg_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_we,
    input logic [bldg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input logic [bldg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [7:0]                          duty,
    input logic                                led_level,
    input logic                                beat_level,
    input logic                                shutdown
);
    import bldg_pkg::*;

    logic [7:0] limit_reg;

    // shadow of the duty limit as seen on the port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= DUTY_LIMIT_RST;
        end
        else if (cfg_we && cfg_index == REG_DUTY_LIMIT)
        begin
            limit_reg <= cfg_data;
        end
    end

    // a cut load shows everything low
    a_shutdown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && shutdown |-> duty == 8'd0 && !led_level && !beat_level)
        else $error("shutdown result with live outputs");

    // delivered duty never exceeds the limit
    a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> duty <= limit_reg)
        else $error("duty above limit");

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its payload
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(duty) && $stable(led_level)
            && $stable(beat_level) && $stable(shutdown))
        else $error("result changed while stalled");

endmodule

bind battery_load_duty_governor_core bldg_checker u_bldg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .duty       (results.duty),
    .led_level  (results.led_level),
    .beat_level (results.beat_level),
    .shutdown   (results.shutdown)
);
